// File: rtl/mrfra_pkg.sv
`default_nettype none

package mrfra_pkg;

    localparam int unsigned RECORDS   = 5;
    localparam int unsigned VALUE_W   = 24;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 112;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FAULT_CODE     = 2'd0;
    localparam logic [1:0] CFG_START_WORD     = 2'd1;
    localparam logic [1:0] CFG_TAG_BASE       = 2'd2;
    localparam logic [1:0] CFG_FORMAT_VERSION = 2'd3;

    typedef enum logic [2:0] {
        ST_NOT_DIAG    = 3'd0,
        ST_STARTED     = 3'd1,
        ST_MALFORMED   = 3'd2,
        ST_IN_PROGRESS = 3'd3,
        ST_COMPLETE    = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0]  fault_code;
        logic [31:0] start_word;
        logic [7:0]  tag_base;
        logic [7:0]  format_version;
    } cfg_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] right_goal;
        logic signed [VALUE_W-1:0] left_goal;
        logic signed [VALUE_W-1:0] right_advance;
        logic signed [VALUE_W-1:0] left_advance;
        logic [1:0]                motion_profile;
        logic [1:0]                motion_mode;
        logic [2:0]                operation;
        status_t                   status;
    } report_t;

endpackage

`default_nettype wire

// File: rtl/multi_record_fault_report_assembler_top.sv
`default_nettype none

// Channel   Direction  Word contents (lowest bit up)
// s_axis    in         error_code[7:0], detail[31:0]
// m_axis    out        status, operation, motion_mode, motion_profile,
//                      left_advance, right_advance, left_goal, right_goal
// cfg       in         cfg_index selects fault_code, start_word, tag_base, format_version
//
// One word per cycle is sustained while m_axis is ready; a result word is offered on m_axis
// from the result register once its input word has moved on from the input register.
// All report assembly is one compare-and-update pass between those two registers.
// Reset clears the assembler store, the valid flags and the configuration to its defaults.
// A stall on m_axis holds the result; s_tready drops only when both registers are full.

module multi_record_fault_report_assembler_top
    import mrfra_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // error_code[7:0], detail[39:8]
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // status, operation, motion_mode,
                                                   // motion_profile, left_advance,
                                                   // right_advance, left_goal,
                                                   // right_goal, zero fill
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [31:0]            cfg_wdata
);

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic [7:0]  code_reg;
    logic [31:0] detail_reg;
    logic        advance;
    logic        out_valid;
    report_t     result;
    report_t     held;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fault_code     <= 8'd0;
            cfg_reg.start_word     <= 32'd0;
            cfg_reg.tag_base       <= 8'd1;
            cfg_reg.format_version <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FAULT_CODE:     cfg_reg.fault_code     <= cfg_wdata[7:0];
                CFG_START_WORD:     cfg_reg.start_word     <= cfg_wdata;
                CFG_TAG_BASE:       cfg_reg.tag_base       <= cfg_wdata[7:0];
                CFG_FORMAT_VERSION: cfg_reg.format_version <= cfg_wdata[7:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The input register moves on whenever the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            code_reg   <= s_tdata[7:0];
            detail_reg <= s_tdata[39:8];
        end
    end

    mrfra_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .error_code (code_reg),
        .detail     (detail_reg),
        .cfg        (cfg_reg),
        .result     (result)
    );

    mrfra_outreg u_outreg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .result (result),
        .take   (m_tready),
        .valid  (out_valid),
        .held   (held)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {6'd0, held.right_goal, held.left_goal, held.right_advance,
                       held.left_advance, held.motion_profile, held.motion_mode,
                       held.operation, 3'(held.status)};

endmodule

`default_nettype wire

// File: rtl/mrfra_core.sv
`default_nettype none

module mrfra_core
    import mrfra_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  error_code,
    input  wire logic [31:0] detail,
    input  wire cfg_t        cfg,
    output report_t          result
);

    logic                armed_reg, armed_next;
    logic [2:0]          pos_reg, pos_next;
    logic [2:0]          op_reg, op_next;
    logic [1:0]          mode_reg, mode_next;
    logic [1:0]          prof_reg, prof_next;
    logic [VALUE_W-1:0]  vals_reg [4];
    logic [VALUE_W-1:0]  vals_next [4];

    logic [8:0] tag9;
    logic [8:0] base9;
    logic [7:0] ver;
    logic [7:0] op_f;
    logic [3:0] mode_f;
    logic [3:0] prof_f;
    logic       ctx_ok;
    logic [1:0] slot;

    assign tag9   = {1'b0, detail[31:24]};
    assign base9  = {1'b0, cfg.tag_base};
    assign ver    = detail[23:16];
    assign op_f   = detail[15:8];
    assign mode_f = detail[7:4];
    assign prof_f = detail[3:0];
    assign slot   = 2'(pos_reg - 3'd1);
    assign ctx_ok = (ver == cfg.format_version) && (op_f >= 8'd1) && (op_f <= 8'd4)
                    && (mode_f >= 4'd1) && (mode_f <= 4'd3) && (prof_f <= 4'd2);

    always_comb
    begin
        result     = '0;
        result.status = ST_NOT_DIAG;
        armed_next = armed_reg;
        pos_next   = pos_reg;
        op_next    = op_reg;
        mode_next  = mode_reg;
        prof_next  = prof_reg;
        for (int i = 0; i < 4; i++)
        begin
            vals_next[i] = vals_reg[i];
        end

        if (error_code != cfg.fault_code)
        begin
            result.status = ST_NOT_DIAG;
        end
        else if (detail == cfg.start_word)
        begin
            result.status = ST_STARTED;
        end
        else if (tag9 < base9 || tag9 > base9 + 9'd4)
        begin
            result.status = ST_NOT_DIAG;
        end
        else if (!armed_reg || pos_reg >= 3'(RECORDS) || tag9 != base9 + {6'd0, pos_reg})
        begin
            result.status = ST_MALFORMED;
        end
        else if (pos_reg == 3'd0)
        begin
            if (ctx_ok)
            begin
                result.status = ST_IN_PROGRESS;
            end
            else
            begin
                result.status = ST_MALFORMED;
            end
        end
        else if (pos_reg == 3'(RECORDS - 1))
        begin
            result.status         = ST_COMPLETE;
            result.operation      = op_reg;
            result.motion_mode    = mode_reg;
            result.motion_profile = prof_reg;
            result.left_advance   = vals_reg[0];
            result.right_advance  = vals_reg[1];
            result.left_goal      = vals_reg[2];
            result.right_goal     = detail[VALUE_W-1:0];
        end
        else
        begin
            result.status = ST_IN_PROGRESS;
        end

        // Every outcome except a report still in progress clears the store.
        if (result.status == ST_IN_PROGRESS)
        begin
            armed_next = 1'b1;
            pos_next   = pos_reg + 3'd1;
            if (pos_reg == 3'd0)
            begin
                op_next   = op_f[2:0];
                mode_next = mode_f[1:0];
                prof_next = prof_f[1:0];
            end
            else
            begin
                vals_next[slot] = detail[VALUE_W-1:0];
            end
        end
        else
        begin
            armed_next = (result.status == ST_STARTED);
            pos_next   = '0;
            op_next    = '0;
            mode_next  = '0;
            prof_next  = '0;
            for (int i = 0; i < 4; i++)
            begin
                vals_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            pos_reg   <= '0;
            op_reg    <= '0;
            mode_reg  <= '0;
            prof_reg  <= '0;
            for (int i = 0; i < 4; i++)
            begin
                vals_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            armed_reg <= armed_next;
            pos_reg   <= pos_next;
            op_reg    <= op_next;
            mode_reg  <= mode_next;
            prof_reg  <= prof_next;
            for (int i = 0; i < 4; i++)
            begin
                vals_reg[i] <= vals_next[i];
            end
        end
    end

`ifndef SYNTHESIS
    // The position only advances while armed, and never past the last value record.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= 3'(RECORDS - 1))
        else $error("record position out of range");

    a_pos_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != 3'd0 |-> armed_reg)
        else $error("record position set while not armed");

    a_complete_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.status == ST_COMPLETE |=> !armed_reg && pos_reg == 3'd0)
        else $error("store not cleared after a complete report");

    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.status == ST_STARTED |=> armed_reg && pos_reg == 3'd0)
        else $error("start word did not arm the assembler");
`endif

endmodule

`default_nettype wire

// File: rtl/mrfra_outreg.sv
`default_nettype none

module mrfra_outreg
    import mrfra_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire report_t result,
    input  wire logic    take,
    output logic         valid,
    output report_t      held
);

    logic    valid_reg, valid_next;
    report_t held_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            held_reg <= result;
        end
    end

    assign valid = valid_reg;
    assign held  = held_reg;

`ifndef SYNTHESIS
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && held_reg.status != ST_COMPLETE |->
            held_reg.operation == '0 && held_reg.motion_mode == '0 &&
            held_reg.motion_profile == '0 && held_reg.left_advance == '0 &&
            held_reg.right_advance == '0 && held_reg.left_goal == '0 &&
            held_reg.right_goal == '0)
        else $error("report fields set on an incomplete report");
`endif

endmodule

`default_nettype wire

// File: verif/multi_record_fault_report_assembler_top_test.sv
`timescale 1ns / 1ps

module multi_record_fault_report_assembler_top_test
    import mrfra_pkg::*;
();

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;     // error_code[7:0], detail[39:8]
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // status, operation, motion_mode,
                                              // motion_profile, left_advance,
                                              // right_advance, left_goal,
                                              // right_goal, zero fill
    logic                   cfg_we = 1'b0;
    logic [1:0]             cfg_index = '0;
    logic [31:0]            cfg_wdata = '0;

    // Register copies, at their reset values.
    logic [7:0]  cur_fault_code = 8'h00;
    logic [31:0] cur_start_word = 32'h0;
    logic [7:0]  cur_tag_base = 8'h01;
    logic [7:0]  cur_version = 8'h01;

    // Report under assembly.
    bit                 armed = 1'b0;
    logic [2:0]         next_record = '0;
    logic [2:0]         held_op = '0;
    logic [1:0]         held_mode = '0;
    logic [1:0]         held_prof = '0;
    logic signed [23:0] held_val [4] = '{default: '0};

    report_t pending_reports [$];
    int      mismatches = 0;
    int      reports_seen = 0;
    int      hold_left = 0;
    bit      gaps_on = 1'b1;
    bit      stall_on = 1'b1;

    multi_record_fault_report_assembler_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic report_t assemble_report(input logic [7:0] code,
                                                input logic [31:0] detail);
        report_t     r;
        logic [7:0]  tag;
        logic [7:0]  ver;
        logic [7:0]  op;
        logic [3:0]  mode;
        logic [3:0]  prof;
        int unsigned tag_top;
        r = '0;
        tag = detail[31:24];
        ver = detail[23:16];
        op = detail[15:8];
        mode = detail[7:4];
        prof = detail[3:0];
        tag_top = cur_tag_base + 4;
        if (code != cur_fault_code)
            r.status = ST_NOT_DIAG;
        else if (detail == cur_start_word)
            r.status = ST_STARTED;
        else if (tag < cur_tag_base || tag > tag_top)
            r.status = ST_NOT_DIAG;
        else if (!armed || next_record >= RECORDS || tag != cur_tag_base + next_record)
            r.status = ST_MALFORMED;
        else if (next_record == 0 && (ver != cur_version || op < 1 || op > 4 ||
                 mode < 1 || mode > 3 || prof > 2))
            r.status = ST_MALFORMED;
        else
        begin
            if (next_record == 0)
            begin
                held_op = op[2:0];
                held_mode = mode[1:0];
                held_prof = prof[1:0];
            end
            else
                held_val[2'(next_record - 3'd1)] = detail[23:0];
            next_record = next_record + 3'd1;
            if (next_record == RECORDS)
            begin
                r.status = ST_COMPLETE;
                r.operation = held_op;
                r.motion_mode = held_mode;
                r.motion_profile = held_prof;
                r.left_advance = held_val[0];
                r.right_advance = held_val[1];
                r.left_goal = held_val[2];
                r.right_goal = held_val[3];
            end
            else
                r.status = ST_IN_PROGRESS;
        end
        // Everything but a record that extends the report clears the store.
        if (r.status != ST_IN_PROGRESS)
        begin
            armed = 1'b0;
            next_record = '0;
            held_op = '0;
            held_mode = '0;
            held_prof = '0;
            held_val = '{default: '0};
        end
        if (r.status == ST_STARTED)
            armed = 1'b1;
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("report %0d %s got %0h expected %0h",
                                    reports_seen, name, got, want));
    endtask

    // Receiver: checks each accepted word, then decides on ready for the next edge.
    always @(posedge clk)
    begin
        report_t got;
        report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = report_t'(m_tdata[$bits(report_t)-1:0]);
            if (pending_reports.size() == 0)
                flag_mismatch("result word with no expected report");
            else
            begin
                want = pending_reports.pop_front();
                check_field("status", 32'(got.status), 32'(want.status));
                check_field("operation", 32'(got.operation), 32'(want.operation));
                check_field("motion_mode", 32'(got.motion_mode), 32'(want.motion_mode));
                check_field("motion_profile", 32'(got.motion_profile),
                            32'(want.motion_profile));
                check_field("left_advance", 32'(got.left_advance),
                            32'(want.left_advance));
                check_field("right_advance", 32'(got.right_advance),
                            32'(want.right_advance));
                check_field("left_goal", 32'(got.left_goal), 32'(want.left_goal));
                check_field("right_goal", 32'(got.right_goal), 32'(want.right_goal));
                check_field("zero fill", 32'(m_tdata[OUT_TDATA_W-1:$bits(report_t)]), '0);
            end
            reports_seen++;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !(stall_on && $urandom_range(99, 0) < 36);
    end

    // Leaves tvalid high after the handshake so that back-to-back words need no toggle.
    task automatic send_word(input logic [7:0] code, input logic [31:0] detail);
        while (gaps_on && $urandom_range(99, 0) < 36)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {detail, code};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_reports.push_back(assemble_report(code, detail));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic load_registers(input logic [7:0] code, input logic [31:0] start,
                                  input logic [7:0] base, input logic [7:0] ver);
        write_reg(CFG_FAULT_CODE, {24'b0, code});
        write_reg(CFG_START_WORD, start);
        write_reg(CFG_TAG_BASE, {24'b0, base});
        write_reg(CFG_FORMAT_VERSION, {24'b0, ver});
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_fault_code = code;
        cur_start_word = start;
        cur_tag_base = base;
        cur_version = ver;
    endtask

    function automatic logic [31:0] context_detail(input logic [7:0] ver,
                                                   input logic [7:0] op,
                                                   input logic [3:0] mode,
                                                   input logic [3:0] prof);
        return {cur_tag_base, ver, op, mode, prof};
    endfunction

    function automatic logic [23:0] pick_value();
        case ($urandom_range(7, 0))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'hFFFFFF;
            3: return 24'h000000;
            default: return 24'($urandom());
        endcase
    endfunction

    // A start word and five records; about one in five has a single word spoiled.
    // pause_at names the word before which the sender waits for all results.
    task automatic send_random_report(input int pause_at);
        logic [7:0]  codes [6];
        logic [31:0] dets [6];
        int          at;
        codes = '{default: cur_fault_code};
        dets[0] = cur_start_word;
        dets[1] = context_detail(cur_version, 8'($urandom_range(4, 1)),
                                 4'($urandom_range(3, 1)), 4'($urandom_range(2, 0)));
        for (int k = 1; k < 5; k++)
            dets[k + 1] = {cur_tag_base + k[7:0], pick_value()};
        if ($urandom_range(99, 0) < 20)
        begin
            at = $urandom_range(5, 0);
            case ($urandom_range(6, 0))
                0: codes[at] = 8'($urandom_range(255, 0));
                1: dets[at][31:24] = 8'($urandom_range(255, 0));
                2: dets[at] = $urandom();
                3: dets[at] = cur_start_word;
                4: dets[1] = context_detail(cur_version, 8'($urandom_range(7, 0)),
                                            4'($urandom_range(15, 0)),
                                            4'($urandom_range(15, 0)));
                5: dets[at][31:24] = 8'(cur_tag_base + $urandom_range(4, 0));
                default: dets[1][23:16] = 8'($urandom_range(255, 0));
            endcase
        end
        for (int i = 0; i < 6; i++)
        begin
            if (i == pause_at)
                wait_drained();
            send_word(codes[i], dets[i]);
        end
    endtask

    task automatic send_noise();
        logic [7:0]  code;
        logic [31:0] detail;
        code = $urandom_range(1, 0) ? cur_fault_code : 8'($urandom_range(255, 0));
        detail = $urandom();
        if ($urandom_range(1, 0))
            detail[31:24] = 8'(cur_tag_base + $urandom_range(4, 0));
        send_word(code, detail);
    endtask

    // Registers still at reset: one full report with the value extremes, then tags
    // just outside the diagnostic range.
    task automatic test_reset_values();
        send_word(8'h00, 32'h0000_0000);
        send_word(8'h00, 32'h0101_0110);
        send_word(8'h00, 32'h0280_0000);
        send_word(8'h00, 32'h037F_FFFF);
        send_word(8'h00, 32'h04FF_FFFF);
        send_word(8'h00, 32'h0500_0000);
        send_word(8'h00, 32'h0600_0000);
        send_word(8'h00, 32'h00FF_FFFF);
        wait_drained();
    endtask

    // Top register extremes, where the last value record carries tag 255.
    task automatic test_special_cases();
        load_registers(8'hFF, 32'hFFFF_FFFF, 8'd251, 8'hFF);
        send_word(8'hFF, {8'd252, 24'h123456});                 // value while not armed
        send_word(8'h00, cur_start_word);                       // foreign error code
        send_word(8'hFF, cur_start_word);
        send_word(8'hFF, context_detail(8'hFE, 8'd4, 4'd3, 4'd2));
        send_word(8'hFF, cur_start_word);
        send_word(8'hFF, context_detail(8'hFF, 8'd5, 4'd1, 4'd0));
        send_word(8'hFF, cur_start_word);
        send_word(8'hFF, context_detail(8'hFF, 8'd0, 4'd0, 4'd0));
        send_word(8'hFF, cur_start_word);
        send_word(8'hFF, context_detail(8'hFF, 8'd3, 4'd4, 4'd3));
        send_word(8'hFF, cur_start_word);
        send_word(8'hFF, context_detail(8'hFF, 8'd4, 4'd3, 4'd2));
        send_word(8'hFF, {8'd253, 24'h000001});                 // skipped a record
        send_word(8'hFF, cur_start_word);
        send_word(8'hFF, context_detail(8'hFF, 8'd1, 4'd1, 4'd0));
        send_word(8'hFF, cur_start_word);                       // restart mid-report
        send_word(8'hFF, context_detail(8'hFF, 8'd2, 4'd2, 4'd1));
        send_word(8'hFF, {8'd252, 24'h7FFFFF});
        send_word(8'hFF, {8'd253, 24'h800000});
        send_word(8'hFF, {8'd254, 24'hFFFFFF});
        send_word(8'hFF, {8'd255, 24'h000001});
        send_word(8'hFF, {8'd252, 24'h000002});                 // store was cleared
        wait_drained();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase == 0)
                load_registers(8'h00, 32'h0, 8'd0, 8'h00);
            else
                load_registers(8'($urandom_range(255, 0)), $urandom(),
                               8'($urandom_range(251, 0)), 8'($urandom_range(255, 0)));
            gaps_on = (phase != 2);
            stall_on = (phase != 2);
            for (int n = 0; n < 19; n++)
            begin
                if ($urandom_range(99, 0) < 15)
                    repeat ($urandom_range(3, 1)) send_noise();
                else
                    send_random_report(-1);
            end
            wait_drained();
        end
        gaps_on = 1'b1;
        stall_on = 1'b1;
    endtask

    // The receiver holds off while words keep coming, so both stages fill up.
    task automatic test_output_stall();
        gaps_on = 1'b0;
        hold_left = 80;
        repeat (8) send_random_report(-1);
        gaps_on = 1'b1;
        wait_drained();
    endtask

    // The sender stops in the middle of reports until every result is back.
    task automatic test_sender_pause();
        for (int n = 0; n < 4; n++)
            send_random_report($urandom_range(5, 1));
        wait_drained();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_special_cases();
        test_random_traffic();
        test_output_stall();
        test_sender_pause();
        wait_drained();
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
